// File: hdl/ieqc_pkg.sv
`default_nettype none

package ieqc_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 8;
    localparam int TYPE_W      = 16;
    localparam int WORD_W      = 32;
    localparam int CFG_AW      = 1;
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 200;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_MOTION = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_MOUSE_MOVE = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_RELATIVE   = 1'd1;

    typedef enum logic [2:0] {
        STS_STORED    = 3'd0,
        STS_COALESCED = 3'd1,
        STS_DROPPED   = 3'd2,
        STS_READ      = 3'd3,
        STS_EMPTY     = 3'd4,
        STS_IGNORED   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COLLAPSE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_SHIFT,
        CMD_SCAN_START,
        CMD_SCAN,
        CMD_COLLAPSE
    } t_cmd_op;

    typedef struct packed {
        logic [TYPE_W-1:0]        kind;
        logic [TYPE_W-1:0]        code;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] extra;
        logic [WORD_W-1:0]        stamp;
    } t_entry;

    typedef struct packed {
        t_cmd_op           op;
        logic [IDX_W-1:0]  slot;
        logic [CNT_W-1:0]  count;
        logic              shift_all;
        logic [TYPE_W-1:0] mm_type;
        logic [TYPE_W-1:0] rel_type;
        t_entry            entry;
    } t_chain_cmd;

    typedef struct packed {
        logic found;
        logic none;
    } t_chain_stat;

endpackage

`default_nettype wire

// File: hdl/ieqc_cell.sv
`default_nettype none

module ieqc_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [ieqc_pkg::IDX_W-1:0] i_idx,
    input  wire ieqc_pkg::t_chain_cmd      i_cmd,
    input  wire ieqc_pkg::t_entry          i_next,
    input  wire logic                      i_tok,
    output ieqc_pkg::t_entry               o_entry,
    output logic                           o_tok,
    output ieqc_pkg::t_chain_stat          o_stat
);
    import ieqc_pkg::*;

    t_entry r_entry, n_entry;
    logic   r_tok, n_tok;
    logic   r_past, n_past;
    logic   w_occ, w_last, w_match;

    assign w_occ   = CNT_W'(i_idx) < i_cmd.count;
    assign w_last  = i_idx == IDX_W'(QUEUE_DEPTH - 1);
    assign w_match = w_occ && (r_entry.kind == i_cmd.mm_type ||
                               r_entry.kind == i_cmd.rel_type);

    assign o_entry     = r_entry;
    assign o_tok       = r_tok & ~w_match;
    assign o_stat.found = r_tok & w_match;
    assign o_stat.none  = r_tok & (~w_occ | (w_last & ~w_match));

    always_comb begin
        n_entry = r_entry;
        n_tok   = 1'b0;
        n_past  = r_past;
        case (i_cmd.op)
            CMD_WRITE: begin
                if (i_idx == i_cmd.slot) begin
                    n_entry = i_cmd.entry;
                end
            end
            CMD_SHIFT: begin
                n_entry = i_next;
            end
            CMD_SCAN_START: begin
                n_tok  = i_idx == '0;
                n_past = 1'b0;
            end
            CMD_SCAN: begin
                n_tok  = i_tok;
                n_past = r_past | (r_tok & ~w_match);
            end
            CMD_COLLAPSE: begin
                if (i_cmd.shift_all || !r_past) begin
                    n_entry = w_last ? i_cmd.entry : i_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_past <= 1'b0;
        end else begin
            r_tok  <= n_tok;
            r_past <= n_past;
        end
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// File: hdl/ieqc_chain.sv
`default_nettype none

module ieqc_chain (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ieqc_pkg::t_chain_cmd i_cmd,
    output ieqc_pkg::t_entry          o_head,
    output ieqc_pkg::t_chain_stat     o_stat
);
    import ieqc_pkg::*;

    t_entry                 w_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_tok;
    logic [QUEUE_DEPTH-1:0] w_found;
    logic [QUEUE_DEPTH-1:0] w_none;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry      w_next;
        logic        w_tok_in;
        t_chain_stat w_cs;

        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign w_next = i_cmd.entry;
        end else begin : g_mid
            assign w_next = w_ent[g+1];
        end

        if (g == 0) begin : g_first
            assign w_tok_in = 1'b0;
        end else begin : g_rest
            assign w_tok_in = w_tok[g-1];
        end

        ieqc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_cmd   (i_cmd),
            .i_next  (w_next),
            .i_tok   (w_tok_in),
            .o_entry (w_ent[g]),
            .o_tok   (w_tok[g]),
            .o_stat  (w_cs)
        );

        assign w_found[g] = w_cs.found;
        assign w_none[g]  = w_cs.none;
    end

    assign o_head       = w_ent[0];
    assign o_stat.found = |w_found;
    assign o_stat.none  = |w_none;

endmodule

`default_nettype wire

// File: hdl/input_event_queue_coalescing.sv
// Apart from a generic push on a full queue, an accepted transaction's result is in the
// output register in the cycle after acceptance. Throughput: one transaction per cycle
// while idle with the output free, set by the single write or shift of the cell row.
// A generic push on a full queue walks a token along the cells to the oldest mouse-move
// or relative entry, then collapses the row, holding off input until the result is out.
// Reset: synchronous, active low; clears counts and counters, restores type defaults.
`default_nettype none

module input_event_queue_coalescing (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ieqc_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [ieqc_pkg::TYPE_W-1:0]     i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // event_type, event_code, value_or_dx, delta_y, timestamp
    input  wire logic [ieqc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // read_type, read_code, read_value, read_extra, read_time, occupancy,
    // dropped_total, coalesced_total
    output logic [ieqc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status
    output logic [2:0]                           m_axis_tuser
);
    import ieqc_pkg::*;

    localparam logic signed [WORD_W:0] SAT_MAX = 33'sd32767;
    localparam logic signed [WORD_W:0] SAT_MIN = -33'sd32768;
    localparam logic [WORD_W-1:0]      CNT_MAX = '1;
    localparam logic [CNT_W-1:0]       FULL    = CNT_W'(QUEUE_DEPTH);

    function automatic logic signed [WORD_W-1:0] f_sat(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s > SAT_MAX) begin
            return SAT_MAX[WORD_W-1:0];
        end else if (s < SAT_MIN) begin
            return SAT_MIN[WORD_W-1:0];
        end
        return s[WORD_W-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_drop, n_drop;
    logic [WORD_W-1:0] r_coal, n_coal;
    logic [TYPE_W-1:0] r_mm, r_rel;
    t_entry            r_nw, n_nw;
    t_entry            r_pend, n_pend;
    logic              r_found, n_found;
    logic              r_ovalid, n_ovalid;
    t_status           r_sts, n_sts;
    t_entry            r_rd, n_rd;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [WORD_W-1:0] r_dtot, n_dtot;
    logic [WORD_W-1:0] r_ctot, n_ctot;

    t_chain_cmd        w_cmd;
    t_entry            w_head;
    t_chain_stat       w_stat;
    logic              w_acc, w_free, w_full, w_nonempty, w_emit;
    t_status           w_sts;
    t_entry            w_rd;
    logic [1:0]        w_op;
    logic [TYPE_W-1:0] w_type, w_code;
    logic signed [WORD_W-1:0] w_v, w_dy;
    logic [WORD_W-1:0] w_ts;

    assign w_type = s_axis_tdata[15:0];
    assign w_code = s_axis_tdata[31:16];
    assign w_v    = $signed(s_axis_tdata[63:32]);
    assign w_dy   = $signed(s_axis_tdata[95:64]);
    assign w_ts   = s_axis_tdata[127:96];
    assign w_op   = s_axis_tuser;

    assign w_free        = ~r_ovalid | m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) & w_free;
    assign w_acc         = s_axis_tvalid & s_axis_tready;
    assign w_full        = r_cnt == FULL;
    assign w_nonempty    = r_cnt != '0;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_sts;
    assign m_axis_tdata  = {r_ctot, r_dtot, r_occ, r_rd.stamp, r_rd.extra, r_rd.value,
                            r_rd.code, r_rd.kind};

    ieqc_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_coal   = r_coal;
        n_nw     = r_nw;
        n_pend   = r_pend;
        n_found  = r_found;
        n_ovalid = r_ovalid & ~m_axis_tready;
        w_emit   = 1'b0;
        w_sts    = STS_IGNORED;
        w_rd     = '0;

        w_cmd.op        = CMD_NONE;
        w_cmd.slot      = IDX_W'(r_cnt);
        w_cmd.count     = r_cnt;
        w_cmd.shift_all = ~r_found;
        w_cmd.mm_type   = r_mm;
        w_cmd.rel_type  = r_rel;
        w_cmd.entry     = r_pend;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_emit = 1'b1;
                    case (w_op)
                        OP_PUSH: begin
                            if (w_type == r_rel && w_nonempty && r_nw.kind == w_type &&
                                r_nw.code == w_code) begin
                                n_nw.value = f_sat(r_nw.value, w_v);
                                n_nw.stamp = w_ts;
                                w_cmd.op    = CMD_WRITE;
                                w_cmd.slot  = IDX_W'(r_cnt - CNT_W'(1));
                                w_cmd.entry = n_nw;
                                n_coal = (r_coal == CNT_MAX) ? r_coal : r_coal + 1'b1;
                                w_sts  = STS_COALESCED;
                            end else if (w_full && w_type == r_rel) begin
                                n_drop = (r_drop == CNT_MAX) ? r_drop : r_drop + 1'b1;
                                w_sts  = STS_DROPPED;
                            end else if (w_full) begin
                                w_emit   = 1'b0;
                                n_pend   = '{w_type, w_code, w_v, '0, w_ts};
                                w_cmd.op = CMD_SCAN_START;
                                n_state  = S_SCAN;
                            end else begin
                                n_nw        = '{w_type, w_code, w_v, '0, w_ts};
                                w_cmd.op    = CMD_WRITE;
                                w_cmd.entry = n_nw;
                                n_cnt       = r_cnt + CNT_W'(1);
                                w_sts       = STS_STORED;
                            end
                        end
                        OP_MOTION: begin
                            if (w_v == '0 && w_dy == '0) begin
                                w_sts = STS_IGNORED;
                            end else if (w_nonempty && r_nw.kind == r_mm) begin
                                n_nw.value  = f_sat(r_nw.value, w_v);
                                n_nw.extra  = f_sat(r_nw.extra, w_dy);
                                n_nw.stamp  = w_ts;
                                w_cmd.op    = CMD_WRITE;
                                w_cmd.slot  = IDX_W'(r_cnt - CNT_W'(1));
                                w_cmd.entry = n_nw;
                                n_coal = (r_coal == CNT_MAX) ? r_coal : r_coal + 1'b1;
                                w_sts  = STS_COALESCED;
                            end else if (w_full) begin
                                n_drop = (r_drop == CNT_MAX) ? r_drop : r_drop + 1'b1;
                                w_sts  = STS_DROPPED;
                            end else begin
                                n_nw        = '{r_mm, '0, w_v, w_dy, w_ts};
                                w_cmd.op    = CMD_WRITE;
                                w_cmd.entry = n_nw;
                                n_cnt       = r_cnt + CNT_W'(1);
                                w_sts       = STS_STORED;
                            end
                        end
                        OP_READ: begin
                            if (!w_nonempty) begin
                                w_sts = STS_EMPTY;
                            end else begin
                                w_rd     = w_head;
                                w_cmd.op = CMD_SHIFT;
                                n_cnt    = r_cnt - CNT_W'(1);
                                w_sts    = STS_READ;
                            end
                        end
                        default: begin
                            w_sts = STS_IGNORED;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_cmd.op = CMD_SCAN;
                if (w_stat.found) begin
                    n_found = 1'b1;
                    n_state = S_COLLAPSE;
                end else if (w_stat.none) begin
                    n_found = 1'b0;
                    n_state = S_COLLAPSE;
                end
            end
            S_COLLAPSE: begin
                if (w_free) begin
                    w_cmd.op = CMD_COLLAPSE;
                    n_nw     = r_pend;
                    if (r_found) begin
                        n_drop = (r_drop == CNT_MAX) ? r_drop : r_drop + 1'b1;
                    end
                    w_emit  = 1'b1;
                    w_sts   = STS_STORED;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_sts  = r_sts;
        n_rd   = r_rd;
        n_occ  = r_occ;
        n_dtot = r_dtot;
        n_ctot = r_ctot;
        if (w_emit) begin
            n_ovalid = 1'b1;
            n_sts    = w_sts;
            n_rd     = w_rd;
            n_occ    = OCC_W'(n_cnt);
            n_dtot   = n_drop;
            n_ctot   = n_coal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_drop   <= '0;
            r_coal   <= '0;
            r_mm     <= TYPE_W'(1);
            r_rel    <= TYPE_W'(2);
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_coal   <= n_coal;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MOUSE_MOVE: r_mm  <= i_cfg_wdata;
                    CFG_RELATIVE:   r_rel <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        r_nw   <= n_nw;
        r_pend <= n_pend;
        r_sts  <= n_sts;
        r_rd   <= n_rd;
        r_occ  <= n_occ;
        r_dtot <= n_dtot;
        r_ctot <= n_ctot;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("occupancy beyond queue depth");

    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_COLLAPSE) |-> w_full)
        else $error("eviction walk on a queue that is not full");

    a_scan_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !(w_stat.found && w_stat.none))
        else $error("token both hit and ran out");

    a_collapse_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLLAPSE && w_free) |=> (r_ovalid && r_sts == STS_STORED &&
                                               r_state == S_IDLE))
        else $error("collapse did not deliver a stored result");

endmodule

`default_nettype wire
